FILE: src/block_usage_checker_unit_macros.svh
// Assertion macros used by the checker file of the block usage checker.
`ifndef BLOCK_USAGE_CHECKER_UNIT_MACROS_SVH
`define BLOCK_USAGE_CHECKER_UNIT_MACROS_SVH

// Same-cycle or sequence property, switched off while reset is asserted.
`define BUC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the following cycle.
`define BUC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/buc_pkg.sv
package buc_pkg;

  // Bitmap geometry.
  localparam int unsigned MAP_BITS   = 65536;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_SEL_W = $clog2(WORD_W);
  localparam int unsigned MAP_WORDS  = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W     = $clog2(MAP_WORDS);
  localparam int unsigned OFF_W      = $clog2(MAP_BITS);
  localparam int unsigned SPAN_W     = $clog2(MAP_BITS + 1);
  localparam int unsigned CNT_W      = $clog2(WORD_W + 1);

  // Field and register widths.
  localparam int unsigned BNO_W       = 24;
  localparam int unsigned CFG_W       = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned WATCH_SLOTS = 4;
  localparam logic [BNO_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_SCAN  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_START = 3'd0,
    CFG_FS_SIZE    = 3'd1,
    CFG_DUP_OFF    = 3'd2,
    CFG_WATCH_A    = 3'd3,
    CFG_WATCH_B    = 3'd4,
    CFG_WATCH_C    = 3'd5,
    CFG_WATCH_D    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    op_e              opcode;
    logic [BNO_W-1:0] block_number;
  } buc_item_t;

  typedef struct packed {
    logic             out_of_range;
    logic             duplicate;
    logic             watched;
    logic [BNO_W-1:0] dup_total;
    logic [BNO_W-1:0] missing_total;
  } buc_result_t;

  // What the word unit reports for one bitmap word under a mask.
  typedef struct packed {
    logic [WORD_W-1:0] merged;
    logic [CNT_W-1:0]  zeros;
    logic              hit;
  } word_res_t;

endpackage

FILE: src/buc_word_unit.sv
module buc_word_unit (
  input  logic [buc_pkg::WORD_W-1:0] word_i,
  input  logic [buc_pkg::WORD_W-1:0] mask_i,
  output buc_pkg::word_res_t         res_o
);

  logic [buc_pkg::WORD_W-1:0] free_bits;
  logic [1:0] lvl1 [16];
  logic [2:0] lvl2 [8];
  logic [3:0] lvl3 [4];
  logic [4:0] lvl4 [2];

  assign free_bits = ~word_i & mask_i;

  // Population count of the unmarked bits as a balanced adder tree.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      lvl1[i] = {1'b0, free_bits[2*i]} + {1'b0, free_bits[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
    end
  end

  assign res_o.zeros  = {1'b0, lvl4[0]} + {1'b0, lvl4[1]};
  assign res_o.merged = word_i | mask_i;
  assign res_o.hit    = |(word_i & mask_i);

endmodule

FILE: src/block_usage_checker_unit.sv
// Channel   Handshake           Payload                 Direction
// item      start / busy        item_i  (buc_item_t)    in
// result    done_o strobe       result_o (buc_result_t) out
// config    cfg_we_i            cfg_idx_i, cfg_data_i   in
//
// A check item passes through the accept edge, a range and watch compare
// state that reads the bitmap word, and a read-modify-write state through the
// word unit; an out-of-range check or one with checking disabled answers from
// the compare state. A scan item reads and then writes back each bitmap word
// in turn; a clear item writes all 2048 words, one word per cycle.
// An empty or disabled scan and the unused opcode answer at once.
// After reset all 2048 bitmap words are swept to zero with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
module block_usage_checker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  buc_pkg::buc_item_t            item_i,
  output logic                          done_o,
  output buc_pkg::buc_result_t          result_o,
  input  logic                          cfg_we_i,
  input  logic [buc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [buc_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_CHK_WR,
    S_SCAN_RD,
    S_SCAN_WR,
    S_CLR
  } state_e;

  // Configuration registers.
  logic [buc_pkg::BNO_W-1:0] data_start_q;
  logic [buc_pkg::BNO_W-1:0] fs_size_q;
  logic                      dup_off_q;
  logic [buc_pkg::BNO_W-1:0] watch_q [buc_pkg::WATCH_SLOTS];

  // Sequencer state.
  state_e                         state_q;
  buc_pkg::buc_item_t             item_q;
  logic [buc_pkg::ADDR_W-1:0]     addr_q;
  logic [buc_pkg::ADDR_W-1:0]     last_q;
  logic [buc_pkg::WORD_SEL_W-1:0] part_q;
  logic [buc_pkg::SPAN_W-1:0]     miss_q;
  logic [buc_pkg::OFF_W-1:0]      off_q;
  logic                           wat_q;
  logic                           clr_rsp_q;
  logic [buc_pkg::BNO_W-1:0]      dup_cnt_q;
  logic                           done_q;
  buc_pkg::buc_result_t           result_q;

  // Bitmap memory.
  logic [buc_pkg::WORD_W-1:0] map_mem [buc_pkg::MAP_WORDS];
  logic [buc_pkg::WORD_W-1:0] rd_data_q;
  logic                       mem_re;
  logic                       mem_we;
  logic [buc_pkg::ADDR_W-1:0] mem_raddr;
  logic [buc_pkg::ADDR_W-1:0] mem_waddr;
  logic [buc_pkg::WORD_W-1:0] mem_wdata;

  // Check decode.
  logic [buc_pkg::BNO_W-1:0]  bno_off;
  logic [buc_pkg::OFF_W-1:0]  chk_off;
  logic                       oor;
  logic                       wat;

  // Scan setup.
  logic [buc_pkg::BNO_W-1:0]  span_diff;
  logic [buc_pkg::BNO_W:0]    span_wide;
  logic [buc_pkg::SPAN_W-1:0] span;
  logic                       scan_empty;

  // Word unit and counters.
  logic [buc_pkg::WORD_W-1:0] mask;
  buc_pkg::word_res_t         wres;
  logic [buc_pkg::BNO_W-1:0]  dup_cnt_inc;
  logic [buc_pkg::SPAN_W-1:0] miss_next;
  logic [buc_pkg::BNO_W-1:0]  miss_sat;
  logic                       accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= buc_pkg::BNO_W'(2);
      fs_size_q    <= '0;
      dup_off_q    <= 1'b0;
      for (int i = 0; i < buc_pkg::WATCH_SLOTS; i++) begin
        watch_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        buc_pkg::CFG_DATA_START: data_start_q <= cfg_data_i;
        buc_pkg::CFG_FS_SIZE:    fs_size_q    <= cfg_data_i;
        buc_pkg::CFG_DUP_OFF:    dup_off_q    <= cfg_data_i[0];
        buc_pkg::CFG_WATCH_A:    watch_q[0]   <= cfg_data_i;
        buc_pkg::CFG_WATCH_B:    watch_q[1]   <= cfg_data_i;
        buc_pkg::CFG_WATCH_C:    watch_q[2]   <= cfg_data_i;
        buc_pkg::CFG_WATCH_D:    watch_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Range test: below the data area, at or past the end of the filesystem, or
  // an offset that does not fit the bitmap.
  assign bno_off = item_q.block_number - data_start_q;
  assign chk_off = buc_pkg::OFF_W'(bno_off);
  assign oor = (item_q.block_number < data_start_q) ||
               (item_q.block_number >= fs_size_q) ||
               ({1'b0, bno_off} >= (buc_pkg::BNO_W + 1)'(buc_pkg::MAP_BITS));

  always_comb begin
    wat = 1'b0;
    for (int i = 0; i < buc_pkg::WATCH_SLOTS; i++) begin
      if ((watch_q[i] != '0) && (watch_q[i] == item_q.block_number)) begin
        wat = 1'b1;
      end
    end
  end

  // The scan covers the data area clipped to the bitmap capacity.
  assign scan_empty = dup_off_q || (fs_size_q <= data_start_q);
  assign span_diff  = fs_size_q - data_start_q;
  assign span_wide  = ({1'b0, span_diff} >= (buc_pkg::BNO_W + 1)'(buc_pkg::MAP_BITS)) ?
                      (buc_pkg::BNO_W + 1)'(buc_pkg::MAP_BITS) : {1'b0, span_diff};
  assign span       = buc_pkg::SPAN_W'(span_wide);

  // Bit mask handed to the word unit: one bit for a check, the in-range bits
  // of the current word for a scan.
  always_comb begin
    mask = '1;
    if (state_q == S_CHK_WR) begin
      mask = buc_pkg::WORD_W'(1) << off_q[buc_pkg::WORD_SEL_W-1:0];
    end else if ((addr_q == last_q) && (part_q != '0)) begin
      mask = ~({buc_pkg::WORD_W{1'b1}} << part_q);
    end
  end

  buc_word_unit u_word_unit (
    .word_i (rd_data_q),
    .mask_i (mask),
    .res_o  (wres)
  );

  assign dup_cnt_inc = (dup_cnt_q != buc_pkg::CNT_MAX) ? dup_cnt_q + 1'b1 : dup_cnt_q;
  assign miss_next   = miss_q + buc_pkg::SPAN_W'(wres.zeros);
  assign miss_sat    = (32'(miss_next) > 32'(buc_pkg::CNT_MAX)) ?
                       buc_pkg::CNT_MAX : buc_pkg::BNO_W'(miss_next);

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = wres.merged;
    case (state_q)
      S_CHK: begin
        mem_re    = !oor && !dup_off_q;
        mem_raddr = buc_pkg::ADDR_W'(chk_off >> buc_pkg::WORD_SEL_W);
      end
      S_CHK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = buc_pkg::ADDR_W'(off_q >> buc_pkg::WORD_SEL_W);
      end
      S_SCAN_RD: begin
        mem_re = 1'b1;
      end
      S_SCAN_WR: begin
        mem_we = 1'b1;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= map_mem[mem_raddr];
    end
  end

  // Sequencer. Reset starts a clearing sweep that gives no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      item_q    <= '0;
      addr_q    <= '0;
      last_q    <= '0;
      part_q    <= '0;
      miss_q    <= '0;
      off_q     <= '0;
      wat_q     <= 1'b0;
      clr_rsp_q <= 1'b0;
      dup_cnt_q <= '0;
      done_q    <= 1'b0;
      result_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q <= item_i;
            case (item_i.opcode)
              buc_pkg::OP_CHECK: begin
                state_q <= S_CHK;
              end
              buc_pkg::OP_SCAN: begin
                if (scan_empty) begin
                  done_q   <= 1'b1;
                  result_q <= '{out_of_range: 1'b0, duplicate: 1'b0, watched: 1'b0,
                                dup_total: dup_cnt_q, missing_total: '0};
                end else begin
                  addr_q  <= '0;
                  miss_q  <= '0;
                  last_q  <= buc_pkg::ADDR_W'((span - 1'b1) >> buc_pkg::WORD_SEL_W);
                  part_q  <= span[buc_pkg::WORD_SEL_W-1:0];
                  state_q <= S_SCAN_RD;
                end
              end
              buc_pkg::OP_CLEAR: begin
                dup_cnt_q <= '0;
                addr_q    <= '0;
                clr_rsp_q <= 1'b1;
                state_q   <= S_CLR;
              end
              default: begin
                // The unused opcode only reports the counter.
                done_q   <= 1'b1;
                result_q <= '{out_of_range: 1'b0, duplicate: 1'b0, watched: 1'b0,
                              dup_total: dup_cnt_q, missing_total: '0};
              end
            endcase
          end
        end
        S_CHK: begin
          if (oor || dup_off_q) begin
            done_q   <= 1'b1;
            result_q <= '{out_of_range: oor, duplicate: 1'b0, watched: wat && !oor,
                          dup_total: dup_cnt_q, missing_total: '0};
            state_q  <= S_IDLE;
          end else begin
            off_q   <= chk_off;
            wat_q   <= wat;
            state_q <= S_CHK_WR;
          end
        end
        S_CHK_WR: begin
          if (wres.hit) begin
            dup_cnt_q <= dup_cnt_inc;
          end
          done_q   <= 1'b1;
          result_q <= '{out_of_range: 1'b0, duplicate: wres.hit, watched: wat_q,
                        dup_total: wres.hit ? dup_cnt_inc : dup_cnt_q,
                        missing_total: '0};
          state_q  <= S_IDLE;
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_WR;
        end
        S_SCAN_WR: begin
          miss_q <= miss_next;
          if (addr_q == last_q) begin
            done_q   <= 1'b1;
            result_q <= '{out_of_range: 1'b0, duplicate: 1'b0, watched: 1'b0,
                          dup_total: dup_cnt_q, missing_total: miss_sat};
            state_q  <= S_IDLE;
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_CLR: begin
          if (addr_q == buc_pkg::ADDR_W'(buc_pkg::MAP_WORDS - 1)) begin
            if (clr_rsp_q) begin
              done_q   <= 1'b1;
              result_q <= '{out_of_range: 1'b0, duplicate: 1'b0, watched: 1'b0,
                            dup_total: dup_cnt_q, missing_total: '0};
            end
            clr_rsp_q <= 1'b0;
            addr_q    <= '0;
            state_q   <= S_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/buc_checker.sv
`include "block_usage_checker_unit_macros.svh"

module buc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input buc_pkg::buc_result_t result_o
);

  logic oor_seen;
  logic oor_clean;
  logic miss_seen;
  logic no_check_flags;

  assign oor_seen       = done_o && result_o.out_of_range;
  assign oor_clean      = !result_o.duplicate && !result_o.watched &&
                          (result_o.missing_total == '0);
  assign miss_seen      = done_o && (result_o.missing_total != '0);
  assign no_check_flags = !result_o.out_of_range && !result_o.duplicate && !result_o.watched;

  // A result is shown only while the block is idle.
  `BUC_ASSERT_RST(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result while busy")

  // An accepted item either keeps the block busy or is answered at once.
  `BUC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy || done_o, "accepted item lost")

  // A scan result that found missing blocks carries no check flags.
  `BUC_ASSERT_RST(a_scan_clean, clk_i, rst_ni, miss_seen |-> no_check_flags, "scan result flags")

  // An out-of-range check result carries no duplicate, watch or missing-block flags.
  `BUC_ASSERT_RST(a_oor_clean, clk_i, rst_ni, oor_seen |-> oor_clean, "out-of-range result flags")

endmodule

bind block_usage_checker_unit buc_checker u_buc_checker (.*);
